>>> sv/segrect_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the segment against rectangle collision pipeline
// no dependencies

package segrect_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   // rectangle edges, in the order left, top, right, bottom
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_TOP    = 1;
   localparam int EDGE_RIGHT  = 2;
   localparam int EDGE_BOTTOM = 3;
   localparam int NUM_EDGES   = 4;

   // rectangle corners
   localparam int CORNER_LT   = 0;
   localparam int CORNER_LB   = 1;
   localparam int CORNER_RT   = 2;
   localparam int CORNER_RB   = 3;
   localparam int NUM_CORNERS = 4;

   // results of the compare-only tests, carried down the pipe
   typedef struct packed {
      logic                 in_rect;
      logic [NUM_EDGES-1:0] edge_straddle;
   } segrect_flags_type;

   // sign of the segment cross product at each corner
   typedef struct packed {
      logic [NUM_CORNERS-1:0] pos;
      logic [NUM_CORNERS-1:0] neg;
   } segrect_sides_type;

endpackage

>>> sv/segrect_diff_stage.sv
`timescale 1ns / 1ps
// first stage: coordinate differences, endpoint-inside test and edge-side straddle tests
// depends on segrect_pkg

module segrect_diff_stage #(
   parameter int COORD_BITS = segrect_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS-1:0]   seg_start_x,
   input  logic signed [COORD_BITS-1:0]   seg_start_y,
   input  logic signed [COORD_BITS-1:0]   seg_end_x,
   input  logic signed [COORD_BITS-1:0]   seg_end_y,
   input  logic signed [COORD_BITS-1:0]   rect_left,
   input  logic signed [COORD_BITS-1:0]   rect_top,
   input  logic signed [COORD_BITS-1:0]   rect_right,
   input  logic signed [COORD_BITS-1:0]   rect_bottom,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [COORD_BITS:0]     left_dx,
   output logic signed [COORD_BITS:0]     right_dx,
   output logic signed [COORD_BITS:0]     top_dy,
   output logic signed [COORD_BITS:0]     bottom_dy,
   output logic signed [COORD_BITS:0]     seg_dx,
   output logic signed [COORD_BITS:0]     seg_dy,
   output segrect_pkg::segrect_flags_type flags
);
   import segrect_pkg::*;

   logic                          valid_ff;
   logic signed [COORD_BITS:0]    left_dx_in, right_dx_in, top_dy_in, bottom_dy_in;
   logic signed [COORD_BITS:0]    seg_dx_in, seg_dy_in;
   logic signed [COORD_BITS:0]    left_dx_ff, right_dx_ff, top_dy_ff, bottom_dy_ff;
   logic signed [COORD_BITS:0]    seg_dx_ff, seg_dy_ff;
   segrect_flags_type             flags_in, flags_ff;
   logic                          start_inside, end_inside;

   // differences taken one bit wider so they are exact
   assign left_dx_in   = $signed({rect_left[COORD_BITS-1], rect_left})
                       - $signed({seg_start_x[COORD_BITS-1], seg_start_x});
   assign right_dx_in  = $signed({rect_right[COORD_BITS-1], rect_right})
                       - $signed({seg_start_x[COORD_BITS-1], seg_start_x});
   assign top_dy_in    = $signed({rect_top[COORD_BITS-1], rect_top})
                       - $signed({seg_start_y[COORD_BITS-1], seg_start_y});
   assign bottom_dy_in = $signed({rect_bottom[COORD_BITS-1], rect_bottom})
                       - $signed({seg_start_y[COORD_BITS-1], seg_start_y});
   assign seg_dx_in    = $signed({seg_end_x[COORD_BITS-1], seg_end_x})
                       - $signed({seg_start_x[COORD_BITS-1], seg_start_x});
   assign seg_dy_in    = $signed({seg_end_y[COORD_BITS-1], seg_end_y})
                       - $signed({seg_start_y[COORD_BITS-1], seg_start_y});

   assign start_inside = (seg_start_x >= rect_left) && (seg_start_x <= rect_right) &&
                         (seg_start_y >= rect_top)  && (seg_start_y <= rect_bottom);
   assign end_inside   = (seg_end_x >= rect_left) && (seg_end_x <= rect_right) &&
                         (seg_end_y >= rect_top)  && (seg_end_y <= rect_bottom);

   always_comb begin
      flags_in.in_rect = start_inside || end_inside;
      // endpoints strictly on opposite sides of each edge line, edge of nonzero length
      flags_in.edge_straddle[EDGE_LEFT] = (rect_top != rect_bottom) &&
         (((seg_start_x < rect_left) && (seg_end_x > rect_left)) ||
          ((seg_start_x > rect_left) && (seg_end_x < rect_left)));
      flags_in.edge_straddle[EDGE_RIGHT] = (rect_top != rect_bottom) &&
         (((seg_start_x < rect_right) && (seg_end_x > rect_right)) ||
          ((seg_start_x > rect_right) && (seg_end_x < rect_right)));
      flags_in.edge_straddle[EDGE_TOP] = (rect_left != rect_right) &&
         (((seg_start_y < rect_top) && (seg_end_y > rect_top)) ||
          ((seg_start_y > rect_top) && (seg_end_y < rect_top)));
      flags_in.edge_straddle[EDGE_BOTTOM] = (rect_left != rect_right) &&
         (((seg_start_y < rect_bottom) && (seg_end_y > rect_bottom)) ||
          ((seg_start_y > rect_bottom) && (seg_end_y < rect_bottom)));
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         left_dx_ff   <= left_dx_in;
         right_dx_ff  <= right_dx_in;
         top_dy_ff    <= top_dy_in;
         bottom_dy_ff <= bottom_dy_in;
         seg_dx_ff    <= seg_dx_in;
         seg_dy_ff    <= seg_dy_in;
         flags_ff     <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign left_dx   = left_dx_ff;
   assign right_dx  = right_dx_ff;
   assign top_dy    = top_dy_ff;
   assign bottom_dy = bottom_dy_ff;
   assign seg_dx    = seg_dx_ff;
   assign seg_dy    = seg_dy_ff;
   assign flags     = flags_ff;

endmodule

>>> sv/segrect_mul_stage.sv
`timescale 1ns / 1ps
// second stage: the four partial products of the corner cross products
// depends on segrect_pkg

module segrect_mul_stage #(
   parameter int COORD_BITS = segrect_pkg::COORD_BITS_DEFAULT,
   localparam int PROD_BITS = 2 * COORD_BITS + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS:0]     left_dx,
   input  logic signed [COORD_BITS:0]     right_dx,
   input  logic signed [COORD_BITS:0]     top_dy,
   input  logic signed [COORD_BITS:0]     bottom_dy,
   input  logic signed [COORD_BITS:0]     seg_dx,
   input  logic signed [COORD_BITS:0]     seg_dy,
   input  segrect_pkg::segrect_flags_type in_flags,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [PROD_BITS-1:0]    left_prod,
   output logic signed [PROD_BITS-1:0]    right_prod,
   output logic signed [PROD_BITS-1:0]    top_prod,
   output logic signed [PROD_BITS-1:0]    bottom_prod,
   output segrect_pkg::segrect_flags_type out_flags
);
   import segrect_pkg::*;

   logic                        valid_ff;
   logic signed [PROD_BITS-1:0] left_prod_in, right_prod_in, top_prod_in, bottom_prod_in;
   logic signed [PROD_BITS-1:0] left_prod_ff, right_prod_ff, top_prod_ff, bottom_prod_ff;
   segrect_flags_type           flags_ff;

   assign left_prod_in   = left_dx * seg_dy;
   assign right_prod_in  = right_dx * seg_dy;
   assign top_prod_in    = top_dy * seg_dx;
   assign bottom_prod_in = bottom_dy * seg_dx;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         left_prod_ff   <= left_prod_in;
         right_prod_ff  <= right_prod_in;
         top_prod_ff    <= top_prod_in;
         bottom_prod_ff <= bottom_prod_in;
         flags_ff       <= in_flags;
      end
   end

   assign out_valid   = valid_ff;
   assign left_prod   = left_prod_ff;
   assign right_prod  = right_prod_ff;
   assign top_prod    = top_prod_ff;
   assign bottom_prod = bottom_prod_ff;
   assign out_flags   = flags_ff;

endmodule

>>> sv/segrect_side_stage.sv
`timescale 1ns / 1ps
// third stage: cross product at each corner and its strict sign
// depends on segrect_pkg

module segrect_side_stage #(
   parameter int COORD_BITS = segrect_pkg::COORD_BITS_DEFAULT,
   localparam int PROD_BITS = 2 * COORD_BITS + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [PROD_BITS-1:0]    left_prod,
   input  logic signed [PROD_BITS-1:0]    right_prod,
   input  logic signed [PROD_BITS-1:0]    top_prod,
   input  logic signed [PROD_BITS-1:0]    bottom_prod,
   input  segrect_pkg::segrect_flags_type in_flags,
   output logic                           out_valid,
   input  logic                           out_ready,
   output segrect_pkg::segrect_sides_type sides,
   output segrect_pkg::segrect_flags_type out_flags
);
   import segrect_pkg::*;

   logic                      valid_ff;
   logic signed [PROD_BITS:0] cross_val [NUM_CORNERS];
   segrect_sides_type         sides_in, sides_ff;
   segrect_flags_type         flags_ff;

   // corner minus segment start, crossed with the segment direction
   assign cross_val[CORNER_LT] = $signed({left_prod[PROD_BITS-1], left_prod})
                               - $signed({top_prod[PROD_BITS-1], top_prod});
   assign cross_val[CORNER_LB] = $signed({left_prod[PROD_BITS-1], left_prod})
                               - $signed({bottom_prod[PROD_BITS-1], bottom_prod});
   assign cross_val[CORNER_RT] = $signed({right_prod[PROD_BITS-1], right_prod})
                               - $signed({top_prod[PROD_BITS-1], top_prod});
   assign cross_val[CORNER_RB] = $signed({right_prod[PROD_BITS-1], right_prod})
                               - $signed({bottom_prod[PROD_BITS-1], bottom_prod});

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         sides_in.neg[i] = cross_val[i][PROD_BITS];
         sides_in.pos[i] = !cross_val[i][PROD_BITS] && (cross_val[i] != '0);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sides_ff <= sides_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign sides     = sides_ff;
   assign out_flags = flags_ff;

endmodule

>>> sv/segment_rect_intersect_unit.sv
`timescale 1ns / 1ps
// segment against axis-aligned rectangle collision test, four register stages
// an accepted req beat passes the diff, mul, side and output registers before rsp_valid
// rate: one beat per cycle unless rsp_ready stalls the four-stage pipeline; bubbles collapse
// reset: synchronous, clears the stage valid bits only; no warm-up after reset
// depends on segrect_pkg, segrect_diff_stage, segrect_mul_stage, segrect_side_stage

module segment_rect_intersect_unit #(
   parameter int COORD_BITS = segrect_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  logic signed [COORD_BITS-1:0] req_rect_left,
   input  logic signed [COORD_BITS-1:0] req_rect_top,
   input  logic signed [COORD_BITS-1:0] req_rect_right,
   input  logic signed [COORD_BITS-1:0] req_rect_bottom,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit
);
   import segrect_pkg::*;

   localparam int PROD_BITS = 2 * COORD_BITS + 2;

   logic                        s1_valid, s2_valid, s3_valid;
   logic                        s2_ready, s3_ready, out_ready;
   logic signed [COORD_BITS:0]  left_dx, right_dx, top_dy, bottom_dy, seg_dx, seg_dy;
   logic signed [PROD_BITS-1:0] left_prod, right_prod, top_prod, bottom_prod;
   segrect_flags_type           s1_flags, s2_flags, s3_flags;
   segrect_sides_type           s3_sides;
   logic [NUM_EDGES-1:0]        edge_cross;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        hit_ff, hit_in;

   segrect_diff_stage #(.COORD_BITS(COORD_BITS)) u_diff (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_right  (req_rect_right),
      .rect_bottom (req_rect_bottom),
      .out_valid   (s1_valid),
      .out_ready   (s2_ready),
      .left_dx     (left_dx),
      .right_dx    (right_dx),
      .top_dy      (top_dy),
      .bottom_dy   (bottom_dy),
      .seg_dx      (seg_dx),
      .seg_dy      (seg_dy),
      .flags       (s1_flags)
   );

   segrect_mul_stage #(.COORD_BITS(COORD_BITS)) u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_ready    (s2_ready),
      .left_dx     (left_dx),
      .right_dx    (right_dx),
      .top_dy      (top_dy),
      .bottom_dy   (bottom_dy),
      .seg_dx      (seg_dx),
      .seg_dy      (seg_dy),
      .in_flags    (s1_flags),
      .out_valid   (s2_valid),
      .out_ready   (s3_ready),
      .left_prod   (left_prod),
      .right_prod  (right_prod),
      .top_prod    (top_prod),
      .bottom_prod (bottom_prod),
      .out_flags   (s2_flags)
   );

   segrect_side_stage #(.COORD_BITS(COORD_BITS)) u_side (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_ready    (s3_ready),
      .left_prod   (left_prod),
      .right_prod  (right_prod),
      .top_prod    (top_prod),
      .bottom_prod (bottom_prod),
      .in_flags    (s2_flags),
      .out_valid   (s3_valid),
      .out_ready   (out_ready),
      .sides       (s3_sides),
      .out_flags   (s3_flags)
   );

   // edge corners strictly on opposite sides of the segment line
   function automatic logic opposite(input segrect_sides_type s, input int a, input int b);
      return (s.pos[a] && s.neg[b]) || (s.neg[a] && s.pos[b]);
   endfunction

   always_comb begin
      edge_cross[EDGE_LEFT]   = s3_flags.edge_straddle[EDGE_LEFT] &&
                                opposite(s3_sides, CORNER_LT, CORNER_LB);
      edge_cross[EDGE_TOP]    = s3_flags.edge_straddle[EDGE_TOP] &&
                                opposite(s3_sides, CORNER_LT, CORNER_RT);
      edge_cross[EDGE_RIGHT]  = s3_flags.edge_straddle[EDGE_RIGHT] &&
                                opposite(s3_sides, CORNER_RT, CORNER_RB);
      edge_cross[EDGE_BOTTOM] = s3_flags.edge_straddle[EDGE_BOTTOM] &&
                                opposite(s3_sides, CORNER_RB, CORNER_LB);
   end

   assign hit_in       = s3_flags.in_rect || (|edge_cross);
   assign out_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = s3_valid;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = hit_ff;

endmodule

>>> sim/segment_rect_intersect_checker.sv
`timescale 1ns / 1ps
// in-order checker for segment_rect_intersect_unit: computes the hit flag of every
// accepted req beat and compares it with the rsp beats as they leave the unit
// depends only on the port widths of the unit

module segment_rect_intersect_checker #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  logic signed [COORD_BITS-1:0] req_rect_left,
   input  logic signed [COORD_BITS-1:0] req_rect_top,
   input  logic signed [COORD_BITS-1:0] req_rect_right,
   input  logic signed [COORD_BITS-1:0] req_rect_bottom,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_hit,
   output int                           errors,
   output int                           outstanding
);

   typedef struct {
      int unsigned serial;
      bit          hit;
   } hit_entry_type;

   hit_entry_type pending_hits[$];
   int unsigned   req_count;
   int unsigned   rsp_count;

   initial begin
      errors      = 0;
      outstanding = 0;
   end

   // sign of the cross product (ax,ay) x (bx,by); products stay well inside 64 bits
   function automatic int turn_sign(input longint ax, ay, bx, by);
      longint d;
      d = ax * by - ay * bx;
      if (d > 0)
         return 1;
      if (d < 0)
         return -1;
      return 0;
   endfunction

   // a and b lie strictly on opposite sides of the line through p and q
   function automatic bit splits(input longint px, py, qx, qy, ax, ay, bx, by);
      int s1, s2;
      s1 = turn_sign(ax - px, ay - py, qx - px, qy - py);
      s2 = turn_sign(bx - px, by - py, qx - px, qy - py);
      return s1 * s2 < 0;
   endfunction

   function automatic bit edge_crossed(input longint px, py, qx, qy, ax, ay, bx, by);
      return splits(px, py, qx, qy, ax, ay, bx, by) && splits(ax, ay, bx, by, px, py, qx, qy);
   endfunction

   function automatic bit segment_hits_rect(input longint sx, sy, ex, ey, l, t, r, b);
      bit start_in, end_in;
      start_in = sx >= l && sx <= r && sy >= t && sy <= b;
      end_in   = ex >= l && ex <= r && ey >= t && ey <= b;
      return start_in || end_in ||
             edge_crossed(l, t, l, b, sx, sy, ex, ey) ||
             edge_crossed(l, t, r, t, sx, sy, ex, ey) ||
             edge_crossed(r, t, r, b, sx, sy, ex, ey) ||
             edge_crossed(r, b, l, b, sx, sy, ex, ey);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      hit_entry_type head;
      if (reset) begin
         pending_hits.delete();
         req_count = 0;
         rsp_count = 0;
      end else begin
         // retire first so a beat can never match a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (pending_hits.size() == 0) begin
               report_mismatch($sformatf("rsp beat %0d (hit %b) with no request waiting",
                                         rsp_count, rsp_hit));
            end else begin
               head = pending_hits.pop_front();
               if (rsp_hit !== head.hit)
                  report_mismatch($sformatf("rsp beat %0d: hit %b, want %b",
                                            head.serial, rsp_hit, head.hit));
            end
            rsp_count++;
         end
         if (req_valid && req_ready) begin
            pending_hits.push_back('{req_count,
               segment_hits_rect(req_seg_start_x, req_seg_start_y,
                                 req_seg_end_x, req_seg_end_y,
                                 req_rect_left, req_rect_top,
                                 req_rect_right, req_rect_bottom)});
            req_count++;
         end
      end
      outstanding <= pending_hits.size();
   end

endmodule

>>> sim/segment_rect_intersect_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for segment_rect_intersect_unit: drives directed and random segment
// and rectangle pairs with random idling on both sides and gives the verdict
// depends on segrect_pkg, segment_rect_intersect_unit, segment_rect_intersect_checker

module segment_rect_intersect_unit_tb;

   localparam int COORD_BITS   = segrect_pkg::COORD_BITS_DEFAULT;
   localparam int CMAX         = 2 ** (COORD_BITS - 1) - 1;
   localparam int CMIN         = -(2 ** (COORD_BITS - 1));
   localparam int RANDOM_PAIRS = 900;
   localparam int RSP_HOLD     = 80;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_seg_start_x, req_seg_start_y, req_seg_end_x, req_seg_end_y;
   coord_type req_rect_left, req_rect_top, req_rect_right, req_rect_bottom;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_hit;

   int          errors;
   int          outstanding;
   int unsigned cycle_count = 0;

   bit quiet     = 1'b0;
   bit src_gaps  = 1'b1;
   bit hold_go   = 1'b0;
   bit hold_done = 1'b0;

   segment_rect_intersect_unit #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_seg_start_x (req_seg_start_x),
      .req_seg_start_y (req_seg_start_y),
      .req_seg_end_x   (req_seg_end_x),
      .req_seg_end_y   (req_seg_end_y),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit)
   );

   segment_rect_intersect_checker #(
      .COORD_BITS(COORD_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_seg_start_x (req_seg_start_x),
      .req_seg_start_y (req_seg_start_y),
      .req_seg_end_x   (req_seg_end_x),
      .req_seg_end_y   (req_seg_end_y),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .errors          (errors),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // rsp side: stall bursts, one long hold-off on request, none once quiet
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   function automatic int clamp_coord(input int v);
      if (v > CMAX)
         return CMAX;
      if (v < CMIN)
         return CMIN;
      return v;
   endfunction

   function automatic int jitter(input int centre, input int span);
      return clamp_coord(centre + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic send_pair(input int sx, sy, ex, ey, l, t, r, b);
      if (!quiet && src_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seg_start_x <= coord_type'(sx);
      req_seg_start_y <= coord_type'(sy);
      req_seg_end_x   <= coord_type'(ex);
      req_seg_end_y   <= coord_type'(ey);
      req_rect_left   <= coord_type'(l);
      req_rect_top    <= coord_type'(t);
      req_rect_right  <= coord_type'(r);
      req_rect_bottom <= coord_type'(b);
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int sx, sy, ex, ey, l, t, r, b;
      int cx, cy, scale, tmp;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_seg_start_x = '0;
      req_seg_start_y = '0;
      req_seg_end_x   = '0;
      req_seg_end_y   = '0;
      req_rect_left   = '0;
      req_rect_top    = '0;
      req_rect_right  = '0;
      req_rect_bottom = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // endpoints inside, through-crossing, clear miss
      send_pair(0, 0, 100, 100, -10, -10, 10, 10);
      send_pair(100, 100, 0, 0, -10, -10, 10, 10);
      send_pair(-100, 0, 100, 0, -10, -10, 10, 10);
      send_pair(-100, 50, 100, 50, -10, -10, 10, 10);
      send_pair(0, -100, 0, 100, -10, -10, 10, 10);
      // running along an edge line and grazing a corner do not count
      send_pair(-100, -10, 100, -10, -10, -10, 10, 10);
      send_pair(0, 20, 20, 0, -10, -10, 10, 10);
      // endpoint exactly on the boundary is inside
      send_pair(10, 10, 50, 70, -10, -10, 10, 10);
      // inverted rectangles
      send_pair(-100, 0, 100, 0, 10, -10, -10, 10);
      send_pair(0, 0, 0, 1, 10, 10, -10, -10);
      send_pair(0, -100, 0, 100, -10, 10, 10, -10);
      // point segments
      send_pair(3, 3, 3, 3, -10, -10, 10, 10);
      send_pair(30, 3, 30, 3, -10, -10, 10, 10);
      send_pair(-10, 10, -10, 10, -10, -10, 10, 10);
      // point rectangle
      send_pair(-5, -5, 5, 5, 0, 0, 0, 0);
      send_pair(0, 0, 5, 9, 0, 0, 0, 0);
      // extremes of the coordinate range
      send_pair(CMIN, CMIN, CMAX, CMAX, -1, 0, 1, 0);
      send_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN + 1, CMIN + 1);
      send_pair(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
      send_pair(CMIN, 0, CMAX, 1, CMIN + 1, CMIN, CMAX - 1, CMAX);
      send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i % 50 == 0)
            src_gaps = $urandom_range(0, 3) != 0;
         if (i == 300) begin
            hold_go  = 1'b1;
            src_gaps = 1'b0;
         end
         quiet = i >= RANDOM_PAIRS - 120;

         case ($urandom_range(0, 3))
            0: scale = 2;
            1: scale = 40;
            2: scale = 1500;
            default: scale = 40000;
         endcase
         cx = int'($urandom_range(0, 65535)) + CMIN;
         cy = int'($urandom_range(0, 65535)) + CMIN;
         l  = jitter(cx, scale);
         r  = jitter(cx, scale);
         t  = jitter(cy, scale);
         b  = jitter(cy, scale);
         if (l > r) begin
            tmp = l; l = r; r = tmp;
         end
         if (t > b) begin
            tmp = t; t = b; b = tmp;
         end
         sx = jitter(cx, 2 * scale);
         sy = jitter(cy, 2 * scale);
         ex = jitter(cx, 2 * scale);
         ey = jitter(cy, 2 * scale);

         case ($urandom_range(0, 9))
            0, 1: begin
               sx = $urandom(); sy = $urandom(); ex = $urandom(); ey = $urandom();
               l  = $urandom(); t  = $urandom(); r  = $urandom(); b  = $urandom();
            end
            7: begin
               // endpoints snapped onto the boundary lines and corners
               sx = $urandom_range(0, 1) ? l : r;
               ey = $urandom_range(0, 1) ? t : b;
               if ($urandom_range(0, 1)) sy = $urandom_range(0, 1) ? t : b;
               if ($urandom_range(0, 1)) ex = $urandom_range(0, 1) ? l : r;
            end
            8: begin
               if ($urandom_range(0, 1)) begin
                  tmp = l; l = r; r = tmp;
               end else begin
                  tmp = t; t = b; b = tmp;
               end
            end
            9: begin
               if ($urandom_range(0, 1)) begin
                  ex = sx; ey = sy;
               end else begin
                  r = l; b = t;
               end
            end
            default: ;
         endcase
         send_pair(sx, sy, ex, ey, l, t, r, b);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
sv/segrect_pkg.sv
sv/segrect_diff_stage.sv
sv/segrect_mul_stage.sv
sv/segrect_side_stage.sv
sv/segment_rect_intersect_unit.sv
sim/segment_rect_intersect_checker.sv
sim/segment_rect_intersect_unit_tb.sv
